// ----- hw/rtl/delimited_frame_checker_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the delimited frame checker
// Wraps concurrent assertions on the block clock and reset so that they can
// be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef DELIMITED_FRAME_CHECKER_TOP_MACROS_SVH
`define DELIMITED_FRAME_CHECKER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset
`define DFC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define DFC_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`else

`define DFC_ASSERT(name, prop, msg)
`define DFC_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

// ----- hw/rtl/dfc_pkg.sv -----
// ---------------------------------------------------------------------------
// dfc_pkg
// Shared types, codes and helpers of the delimited frame checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfc_pkg;

   localparam logic [7:0] START_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] CHECK_BASE = 8'hFF;
   localparam logic [15:0] CNT_MAX   = 16'hFFFF;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_LEN_HI = 3'd1,
      PH_LEN_LO = 3'd2,
      PH_DATA   = 3'd3,
      PH_CHECK  = 3'd4,
      PH_AFTER  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_LEN_BAD = 2'd0,
      ST_CK_OK   = 2'd1,
      ST_CK_BAD  = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_flush;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  frame_status;
      logic [15:0] frame_escapes;
      logic [15:0] total_frames;
      logic [15:0] length_ok_count;
      logic [15:0] length_bad_count;
      logic [15:0] checksum_ok_count;
      logic [15:0] checksum_bad_count;
      logic [15:0] escape_total;
   } rsp_payload_type;

   // Handshake between the parser and the stages around it
   typedef struct packed {
      logic item_valid;
      logic advance;
   } step_ctrl_type;

   // Saturating increment of a 16-bit counter
   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      logic [15:0] r;
      r = (v == CNT_MAX) ? v : v + 16'd1;
      return r;
   endfunction

endpackage

// ----- hw/rtl/dfc_in_stage.sv -----
// ---------------------------------------------------------------------------
// dfc_in_stage
// Input register: holds one request transaction until the parser consumes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfc_in_stage import dfc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            advance,
   output logic            item_valid,
   output req_payload_type item
);

   logic            valid_ff;
   logic            valid_in;
   req_payload_type item_ff;

   // Take a new transaction when empty or when the held one moves on
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- hw/rtl/dfc_parser.sv -----
// ---------------------------------------------------------------------------
// dfc_parser
// Frame state machine, running sum, byte count and saturating counters.
// Works out the result of one item in a single pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "delimited_frame_checker_top_macros.svh"

module dfc_parser import dfc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  step_ctrl_type   ctrl,
   input  req_payload_type item,
   output logic            emit,
   output rsp_payload_type result
);

   phase_type   phase_ff, phase_in;
   logic [15:0] decl_len_ff, decl_len_in;
   logic [15:0] count_ff, count_in;
   logic        last_esc_ff, last_esc_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  held_ck_ff, held_ck_in;
   logic [15:0] frame_esc_ff, frame_esc_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] len_ok_ff, len_ok_in;
   logic [15:0] len_bad_ff, len_bad_in;
   logic [15:0] ck_ok_ff, ck_ok_in;
   logic [15:0] ck_bad_ff, ck_bad_in;
   logic [15:0] esc_total_ff, esc_total_in;

   logic        do_close;
   logic        close_good;
   logic        do_open;
   logic        do_escape;
   logic        do_data;
   logic        ck_match;
   logic [7:0]  b;
   logic [15:0] count_inc;
   status_type  status;

   assign b         = item.data_byte;
   assign count_inc = count_ff + 16'd1;

   // Decode frame events and next phase
   always_comb begin
      phase_in   = phase_ff;
      do_close   = 1'b0;
      close_good = 1'b0;
      do_open    = 1'b0;
      do_escape  = 1'b0;
      do_data    = 1'b0;
      if (item.is_flush) begin
         if (phase_ff != PH_HUNT) begin
            do_close   = 1'b1;
            close_good = (phase_ff == PH_AFTER);
            phase_in   = PH_HUNT;
         end
      end else begin
         unique case (phase_ff)
            PH_LEN_HI: begin
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               phase_in = ({decl_len_ff[15:8], b} == 16'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
               if (b == START_BYTE) begin
                  if (last_esc_ff) begin
                     do_escape = 1'b1;
                  end else begin
                     do_close = 1'b1;
                     do_open  = 1'b1;
                  end
               end else begin
                  do_data = 1'b1;
                  if (count_inc == decl_len_ff) begin
                     phase_in = PH_CHECK;
                  end
               end
            end
            PH_CHECK: begin
               phase_in = PH_AFTER;
            end
            PH_AFTER: begin
               do_close = 1'b1;
               if (b == START_BYTE) begin
                  close_good = 1'b1;
                  do_open    = 1'b1;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               // Hunting, and any code outside the frame phases
               phase_in = PH_HUNT;
               if (b == START_BYTE) begin
                  do_open = 1'b1;
               end
            end
         endcase
         if (do_open) begin
            phase_in = PH_LEN_HI;
         end
      end
   end

   // Update frame datapath
   always_comb begin
      decl_len_in = decl_len_ff;
      count_in    = count_ff;
      last_esc_in = last_esc_ff;
      sum_in      = sum_ff;
      held_ck_in  = held_ck_ff;
      if (!item.is_flush) begin
         if (phase_ff == PH_LEN_HI) begin
            decl_len_in = {b, 8'h00};
         end
         if (phase_ff == PH_LEN_LO) begin
            decl_len_in = {decl_len_ff[15:8], b};
         end
         if (phase_ff == PH_CHECK) begin
            held_ck_in = b;
         end
      end
      if (do_data) begin
         sum_in      = sum_ff + b;
         count_in    = count_inc;
         last_esc_in = (b == ESC_BYTE);
      end
      if (do_escape) begin
         // Take the escape byte back out of the sum and add the start byte
         sum_in      = sum_ff - ESC_BYTE + START_BYTE;
         last_esc_in = 1'b0;
      end
      if (do_open) begin
         decl_len_in = '0;
         count_in    = '0;
         last_esc_in = 1'b0;
         sum_in      = '0;
         held_ck_in  = '0;
      end
   end

   // Update counters and build the result
   assign ck_match = (held_ck_ff == CHECK_BASE - sum_ff);

   always_comb begin
      total_in     = do_open ? sat_inc(total_ff) : total_ff;
      esc_total_in = do_escape ? sat_inc(esc_total_ff) : esc_total_ff;
      frame_esc_in = frame_esc_ff;
      if (do_escape) begin
         frame_esc_in = sat_inc(frame_esc_ff);
      end
      if (do_open) begin
         frame_esc_in = '0;
      end
      len_ok_in  = len_ok_ff;
      len_bad_in = len_bad_ff;
      ck_ok_in   = ck_ok_ff;
      ck_bad_in  = ck_bad_ff;
      status     = ST_LEN_BAD;
      if (do_close) begin
         if (!close_good) begin
            len_bad_in = sat_inc(len_bad_ff);
            status     = ST_LEN_BAD;
         end else begin
            len_ok_in = sat_inc(len_ok_ff);
            if (ck_match) begin
               ck_ok_in = sat_inc(ck_ok_ff);
               status   = ST_CK_OK;
            end else begin
               ck_bad_in = sat_inc(ck_bad_ff);
               status    = ST_CK_BAD;
            end
         end
      end
   end

   assign emit                      = ctrl.item_valid && do_close;
   assign result.frame_status       = status;
   assign result.frame_escapes      = frame_esc_ff;
   assign result.total_frames       = total_ff;
   assign result.length_ok_count    = len_ok_in;
   assign result.length_bad_count   = len_bad_in;
   assign result.checksum_ok_count  = ck_ok_in;
   assign result.checksum_bad_count = ck_bad_in;
   assign result.escape_total       = esc_total_ff;

   // Commit state when the item moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         decl_len_ff  <= '0;
         count_ff     <= '0;
         last_esc_ff  <= 1'b0;
         sum_ff       <= '0;
         held_ck_ff   <= '0;
         frame_esc_ff <= '0;
         total_ff     <= '0;
         len_ok_ff    <= '0;
         len_bad_ff   <= '0;
         ck_ok_ff     <= '0;
         ck_bad_ff    <= '0;
         esc_total_ff <= '0;
      end else if (ctrl.advance) begin
         phase_ff     <= phase_in;
         decl_len_ff  <= decl_len_in;
         count_ff     <= count_in;
         last_esc_ff  <= last_esc_in;
         sum_ff       <= sum_in;
         held_ck_ff   <= held_ck_in;
         frame_esc_ff <= frame_esc_in;
         total_ff     <= total_in;
         len_ok_ff    <= len_ok_in;
         len_bad_ff   <= len_bad_in;
         ck_ok_ff     <= ck_ok_in;
         ck_bad_ff    <= ck_bad_in;
         esc_total_ff <= esc_total_in;
      end
   end

   `DFC_ASSERT(a_total_monotonic, 1'b1 |=> total_ff >= $past(total_ff), "frame total went down")
   `DFC_ASSERT(a_esc_total_covers_frame, esc_total_ff >= frame_esc_ff, "escape total too low")
   `DFC_ASSERT(a_check_after_full_count, phase_ff == PH_CHECK |-> count_ff == decl_len_ff, "checksum phase before all data bytes")
   `DFC_ASSERT(a_no_result_while_hunting, emit |-> phase_ff != PH_HUNT, "result emitted while hunting")

endmodule

// ----- hw/rtl/dfc_out_stage.sv -----
// ---------------------------------------------------------------------------
// dfc_out_stage
// Result register: holds one response transaction until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfc_out_stage import dfc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  rsp_payload_type result,
   output logic            out_free,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type payload_ff;

   // Room for a new result when empty or when the held one leaves now
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

// ----- hw/rtl/delimited_frame_checker_top.sv -----
// Delimited frame checker: takes one stream byte (or an end-of-stream flush)
// per request transaction, at a sustained rate of one transaction per clock,
// and returns one response transaction for every frame it closes, carrying the
// frame status, its escape count and the running saturating counters. An item
// is held in the input register while the frame state and counters are
// updated in one pass, and its result is registered in the response register
// as the item moves on; transactions stall only when a result is due while the
// response register is still full.
// ---------------------------------------------------------------------------
// delimited_frame_checker_top
// Top level: input register, frame parser and response register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module delimited_frame_checker_top import dfc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            item_valid;
   req_payload_type item;
   logic            emit;
   logic            out_free;
   rsp_payload_type result;
   step_ctrl_type   ctrl;

   // Advance unless a result is due and the response register is full
   assign ctrl.item_valid = item_valid;
   assign ctrl.advance    = item_valid && (!emit || out_free);

   dfc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .advance     (ctrl.advance),
      .item_valid  (item_valid),
      .item        (item)
   );

   dfc_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .item   (item),
      .emit   (emit),
      .result (result)
   );

   dfc_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (ctrl.advance && emit),
      .result      (result),
      .out_free    (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- bench/delimited_frame_checker_top_tb.sv -----
// ---------------------------------------------------------------------------
// delimited_frame_checker_top_tb
// Self-checking bench for the delimited frame checker. A queue of stream
// bytes and flushes (a directed opening, then random frames, broken frames
// and line noise) feeds a valid/ready driver. Every accepted transaction runs
// through a frame tracker kept in the bench, and each response transaction is
// compared field by field with the oldest predicted frame result. Both
// channels idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module delimited_frame_checker_top_tb;
   import dfc_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int STREAM_ITEMS = 1550;

   // Slots of the running frame tallies
   localparam int TALLY_STARTED = 0;
   localparam int TALLY_LEN_OK = 1;
   localparam int TALLY_LEN_BAD = 2;
   localparam int TALLY_CK_OK = 3;
   localparam int TALLY_CK_BAD = 4;
   localparam int TALLY_ESC = 5;

   logic            clock;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   req_payload_type pending_items[$];
   rsp_payload_type expected_frames[$];

   // Frame tracker state
   phase_type   cur_phase = PH_HUNT;
   logic [15:0] want_len = '0;
   logic [15:0] data_seen = '0;
   logic        escape_pending = 1'b0;
   logic [7:0]  sum_acc = '0;
   logic [7:0]  check_byte = '0;
   logic [15:0] frame_esc = '0;
   logic [15:0] tally[6] = '{default: '0};

   int  fail_count = 0;
   int  cycle_count = 0;
   int  framed_items = 0;
   bit  gen_open = 1'b0;
   bit  req_took = 1'b0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   int  req_idle_pct = 0;
   int  rsp_idle_pct = 0;

   delimited_frame_checker_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] count_up(input logic [15:0] v);
      return (&v) ? v : v + 16'd1;
   endfunction

   // Open a new frame on a start byte
   task automatic start_frame();
      tally[TALLY_STARTED] = count_up(tally[TALLY_STARTED]);
      want_len = '0;
      data_seen = '0;
      escape_pending = 1'b0;
      sum_acc = '0;
      check_byte = '0;
      frame_esc = '0;
      cur_phase = PH_LEN_HI;
   endtask

   // Close the current frame and queue the result it must produce
   task automatic finish_frame(input bit length_good);
      rsp_payload_type res;
      status_type      st;
      if (!length_good) begin
         tally[TALLY_LEN_BAD] = count_up(tally[TALLY_LEN_BAD]);
         st = ST_LEN_BAD;
      end else begin
         tally[TALLY_LEN_OK] = count_up(tally[TALLY_LEN_OK]);
         if (check_byte == 8'(CHECK_BASE - sum_acc)) begin
            tally[TALLY_CK_OK] = count_up(tally[TALLY_CK_OK]);
            st = ST_CK_OK;
         end else begin
            tally[TALLY_CK_BAD] = count_up(tally[TALLY_CK_BAD]);
            st = ST_CK_BAD;
         end
      end
      res.frame_status = st;
      res.frame_escapes = frame_esc;
      res.total_frames = tally[TALLY_STARTED];
      res.length_ok_count = tally[TALLY_LEN_OK];
      res.length_bad_count = tally[TALLY_LEN_BAD];
      res.checksum_ok_count = tally[TALLY_CK_OK];
      res.checksum_bad_count = tally[TALLY_CK_BAD];
      res.escape_total = tally[TALLY_ESC];
      expected_frames.push_back(res);
   endtask

   // Advance the frame tracker by one accepted transaction
   task automatic track_frame(input req_payload_type item);
      logic [7:0] b;
      b = item.data_byte;
      if (item.is_flush) begin
         if (cur_phase != PH_HUNT) begin
            finish_frame(cur_phase == PH_AFTER);
            cur_phase = PH_HUNT;
         end
      end else begin
         case (cur_phase)
            PH_HUNT: begin
               if (b == START_BYTE) start_frame();
            end
            PH_LEN_HI: begin
               want_len = {b, 8'h00};
               cur_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               want_len[7:0] = b;
               cur_phase = (want_len == 16'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
               if (b == START_BYTE && !escape_pending) begin
                  finish_frame(1'b0);
                  start_frame();
               end else if (b == START_BYTE) begin
                  // escaped start byte: swap the escape byte out of the sum
                  frame_esc = count_up(frame_esc);
                  tally[TALLY_ESC] = count_up(tally[TALLY_ESC]);
                  sum_acc = sum_acc - ESC_BYTE + START_BYTE;
                  escape_pending = 1'b0;
               end else begin
                  sum_acc = sum_acc + b;
                  data_seen = data_seen + 16'd1;
                  escape_pending = (b == ESC_BYTE);
                  if (data_seen == want_len) cur_phase = PH_CHECK;
               end
            end
            PH_CHECK: begin
               check_byte = b;
               cur_phase = PH_AFTER;
            end
            default: begin
               if (b == START_BYTE) begin
                  finish_frame(1'b1);
                  start_frame();
               end else begin
                  finish_frame(1'b0);
                  cur_phase = PH_HUNT;
               end
            end
         endcase
      end
   endtask

   function automatic bit field_matches(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d (0x%h) got %0d (0x%h)", $time, name, want, want,
                  got, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic check_frame(input rsp_payload_type want, input rsp_payload_type got);
      bit ok;
      ok = field_matches("frame_status", 16'(want.frame_status), 16'(got.frame_status));
      ok &= field_matches("frame_escapes", want.frame_escapes, got.frame_escapes);
      ok &= field_matches("total_frames", want.total_frames, got.total_frames);
      ok &= field_matches("length_ok_count", want.length_ok_count, got.length_ok_count);
      ok &= field_matches("length_bad_count", want.length_bad_count, got.length_bad_count);
      ok &= field_matches("checksum_ok_count", want.checksum_ok_count,
                          got.checksum_ok_count);
      ok &= field_matches("checksum_bad_count", want.checksum_bad_count,
                          got.checksum_bad_count);
      ok &= field_matches("escape_total", want.escape_total, got.escape_total);
      if (!ok) fail_count++;
   endtask

   // Mostly no gap; otherwise short gaps with an occasional long one
   function automatic int pick_gap(input int idle_pct);
      int r;
      if ($urandom_range(0, 99) >= idle_pct) return 0;
      r = $urandom_range(0, 99);
      return (r < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 20;
         default: return 50;
      endcase
   endfunction

   // Stimulus queue helpers
   task automatic push_item(input logic [7:0] b, input logic flush, input bit counts);
      req_payload_type item;
      item.data_byte = b;
      item.is_flush = flush;
      pending_items.push_back(item);
      if (counts) framed_items++;
   endtask

   task automatic put_byte(input logic [7:0] b);
      push_item(b, 1'b0, 1'b1);
   endtask

   task automatic put_flush();
      push_item(8'($urandom), 1'b1, 1'b1);
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom);
      while (b == START_BYTE || b == ESC_BYTE) b = 8'($urandom);
      return b;
   endfunction

   // Well-formed frame with random content, mostly a correct checksum
   task automatic queue_good_frame();
      int         len;
      int         roll;
      logic [7:0] sum;
      logic [7:0] b;
      roll = $urandom_range(0, 99);
      len = (roll < 80) ? $urandom_range(0, 6) :
            (roll < 97) ? $urandom_range(7, 24) : $urandom_range(25, 60);
      if (!gen_open) put_byte(START_BYTE);
      put_byte(8'(len >> 8));
      put_byte(8'(len));
      sum = '0;
      for (int i = 0; i < len; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 10 && i < len - 1) begin
            put_byte(ESC_BYTE);
            put_byte(START_BYTE);
            sum = sum + START_BYTE;
         end else if (roll < 22) begin
            put_byte(ESC_BYTE);
            sum = sum + ESC_BYTE;
         end else begin
            b = 8'($urandom);
            while (b == START_BYTE) b = 8'($urandom);
            put_byte(b);
            sum = sum + b;
         end
      end
      put_byte(($urandom_range(0, 99) < 85) ? 8'(CHECK_BASE - sum) : 8'($urandom));
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         put_byte(START_BYTE);
         gen_open = 1'b1;
      end else if (roll < 80) begin
         put_flush();
         gen_open = 1'b0;
      end else begin
         put_byte(plain_byte());
         gen_open = 1'b0;
      end
   endtask

   // Frame cut short by a flush or a bare start byte
   task automatic queue_broken_frame();
      int mode;
      int k;
      mode = $urandom_range(0, 3);
      k = $urandom_range(0, 3);
      if (!gen_open) put_byte(START_BYTE);
      gen_open = 1'b0;
      if (mode == 0) begin
         put_byte(8'($urandom));
         put_flush();
      end else if (mode == 3) begin
         // flush while the checksum byte is due
         put_byte(8'h00);
         put_byte(8'(k));
         repeat (k) put_byte(plain_byte());
         put_flush();
      end else begin
         if ($urandom_range(0, 1)) begin
            put_byte(8'($urandom_range(1, 255)));
            put_byte(8'($urandom));
         end else begin
            put_byte(8'h00);
            put_byte(8'($urandom_range(8, 255)));
         end
         repeat (k) put_byte(plain_byte());
         if (mode == 1) begin
            put_flush();
         end else begin
            put_byte(START_BYTE);
            gen_open = 1'b1;
         end
      end
   endtask

   // Line noise while hunting
   task automatic queue_noise();
      if (gen_open) return;
      repeat ($urandom_range(1, 4)) push_item(plain_byte(), 1'b0, 1'b0);
      if ($urandom_range(0, 9) < 3) push_item(8'($urandom), 1'b1, 1'b0);
   endtask

   // Request driver: hold each transaction until accepted, then idle at random
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_took)) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap = req_gap - 1;
         end else if (pending_items.size() > 0) begin
            req_payload <= pending_items.pop_front();
            req_valid <= 1'b1;
            req_gap = pick_gap(req_idle_pct);
            if ($urandom_range(0, 149) == 0) req_idle_pct = pick_idle_pct();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response backpressure
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall = pick_gap(rsp_idle_pct);
         if ($urandom_range(0, 149) == 0) rsp_idle_pct = pick_idle_pct();
      end
   end

   // Monitor: track accepted requests, check responses, bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         req_took = !reset && req_valid && req_ready;
         if (req_took) track_frame(req_payload);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               fail_count++;
               $display("%0t: response with no frame pending, expected none got %p",
                        $time, rsp_payload);
            end else begin
               check_frame(expected_frames.pop_front(), rsp_payload);
            end
         end
      end
   end

   initial begin
      // Directed opening
      put_flush();                        // flush while hunting
      put_byte(8'h00);                    // skipped while hunting
      put_byte(START_BYTE);               // zero length, good checksum
      put_byte(8'h00);
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(START_BYTE);               // trailer start byte opens the next frame
      put_byte(ESC_BYTE);                 // escape byte in the length field
      put_byte(START_BYTE);
      put_byte(START_BYTE);               // bare start byte in data
      put_byte(8'h00);
      put_byte(8'h03);
      put_byte(8'h41);
      put_byte(ESC_BYTE);                 // escaped start byte in data
      put_byte(START_BYTE);
      put_byte(8'h42);
      put_byte(START_BYTE);               // start byte as checksum
      put_flush();                        // flush as trailer
      put_byte(START_BYTE);
      put_byte(8'h00);
      put_byte(8'h01);
      put_byte(8'h05);
      put_byte(ESC_BYTE);                 // escape byte as checksum
      put_byte(8'h33);                    // bad trailer, frame counted as length bad
      put_byte(START_BYTE);
      put_byte(8'h00);
      put_byte(8'h02);
      put_flush();                        // early flush in data
      framed_items = 0;

      // Random part
      while (framed_items < STREAM_ITEMS) begin
         case ($urandom_range(0, 99) / 25)
            0, 1, 2: queue_good_frame();
            default: begin
               if ($urandom_range(0, 1)) queue_broken_frame();
               else queue_noise();
            end
         endcase
      end
      put_flush();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() > 0 || req_valid) @(posedge clock);
      while (expected_frames.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
